FILE: rtl/wsdf_pkg.sv
`default_nettype none

package wsdf_pkg;

    // width of the payload length counter, 16 to 64
    localparam int LENGTH_WIDTH = 64;

    localparam logic [7:0] FIRST_BYTE_TEXT = 8'h81;
    localparam logic [6:0] LEN_CODE_EXT16  = 7'd126;
    localparam logic [6:0] LEN_CODE_EXT64  = 7'd127;
    localparam logic [3:0] EXT16_BYTES     = 4'd2;
    localparam logic [3:0] EXT64_BYTES     = 4'd8;
    localparam logic [3:0] KEY_BYTES       = 4'd4;

    // parser phase, one-hot
    typedef enum logic [4:0] {
        PH_FIRST   = 5'b00001,
        PH_LENGTH  = 5'b00010,
        PH_EXTLEN  = 5'b00100,
        PH_KEY     = 5'b01000,
        PH_PAYLOAD = 5'b10000
    } wsdf_phase_t;

    typedef struct packed {
        logic [7:0] payload_byte;
        logic       last_of_frame;
        logic       empty_frame;
        logic       frame_error;
    } wsdf_result_t;

endpackage

`default_nettype wire

FILE: rtl/wsdf_parser.sv
`default_nettype none

module wsdf_parser (
    input  wire logic                  clk,
    input  wire logic                  rst_n,
    input  wire logic                  step,
    input  wire logic [7:0]            data,
    output logic                       res_valid,
    output wsdf_pkg::wsdf_result_t     res
);
    import wsdf_pkg::*;

    wsdf_phase_t             phase_reg, phase_next;
    logic [3:0]              hdr_left_reg, hdr_left_next;
    logic [LENGTH_WIDTH-1:0] remaining_reg, remaining_next;
    logic [31:0]             key_reg, key_next;
    logic                    mask_on_reg, mask_on_next;
    logic [1:0]              key_pos_reg, key_pos_next;
    logic                    closed_reg, closed_next;

    logic [6:0]              len_code;
    logic [LENGTH_WIDTH-1:0] ext_len;
    logic [3:0]              hdr_left_dec;
    logic [7:0]              key_byte;

    assign len_code     = data[6:0];
    assign ext_len      = {remaining_reg[LENGTH_WIDTH-9:0], data};
    assign hdr_left_dec = hdr_left_reg - 4'd1;

    // key byte for this payload position, first key byte in the top
    always_comb
    begin
        case (key_pos_reg)
            2'd0:    key_byte = key_reg[31:24];
            2'd1:    key_byte = key_reg[23:16];
            2'd2:    key_byte = key_reg[15:8];
            default: key_byte = key_reg[7:0];
        endcase
    end

    // parser step for one item
    always_comb
    begin
        phase_next     = phase_reg;
        hdr_left_next  = hdr_left_reg;
        remaining_next = remaining_reg;
        key_next       = key_reg;
        mask_on_next   = mask_on_reg;
        key_pos_next   = key_pos_reg;
        closed_next    = closed_reg;
        res_valid      = 1'b0;
        res            = '0;

        if (step && !closed_reg)
        begin
            unique case (phase_reg)
                PH_FIRST:
                begin
                    if (data != FIRST_BYTE_TEXT)
                    begin
                        closed_next     = 1'b1;
                        res_valid       = 1'b1;
                        res.frame_error = 1'b1;
                    end
                    else
                    begin
                        phase_next = PH_LENGTH;
                    end
                end
                PH_LENGTH:
                begin
                    mask_on_next = data[7];
                    if (len_code == LEN_CODE_EXT16 || len_code == LEN_CODE_EXT64)
                    begin
                        remaining_next = '0;
                        phase_next     = PH_EXTLEN;
                        hdr_left_next  = (len_code == LEN_CODE_EXT16) ? EXT16_BYTES
                                                                      : EXT64_BYTES;
                    end
                    else
                    begin
                        remaining_next = LENGTH_WIDTH'(len_code);
                        if (data[7])
                        begin
                            phase_next    = PH_KEY;
                            hdr_left_next = KEY_BYTES;
                        end
                        else
                        begin
                            key_pos_next = 2'd0;
                            if (len_code == 7'd0)
                            begin
                                phase_next        = PH_FIRST;
                                res_valid         = 1'b1;
                                res.last_of_frame = 1'b1;
                                res.empty_frame   = 1'b1;
                            end
                            else
                            begin
                                phase_next = PH_PAYLOAD;
                            end
                        end
                    end
                end
                PH_EXTLEN:
                begin
                    remaining_next = ext_len;
                    hdr_left_next  = hdr_left_dec;
                    if (hdr_left_dec == 4'd0)
                    begin
                        if (mask_on_reg)
                        begin
                            phase_next    = PH_KEY;
                            hdr_left_next = KEY_BYTES;
                        end
                        else
                        begin
                            key_pos_next = 2'd0;
                            if (ext_len == '0)
                            begin
                                phase_next        = PH_FIRST;
                                res_valid         = 1'b1;
                                res.last_of_frame = 1'b1;
                                res.empty_frame   = 1'b1;
                            end
                            else
                            begin
                                phase_next = PH_PAYLOAD;
                            end
                        end
                    end
                end
                PH_KEY:
                begin
                    key_next      = {key_reg[23:0], data};
                    hdr_left_next = hdr_left_dec;
                    if (hdr_left_dec == 4'd0)
                    begin
                        key_pos_next = 2'd0;
                        if (remaining_reg == '0)
                        begin
                            phase_next        = PH_FIRST;
                            res_valid         = 1'b1;
                            res.last_of_frame = 1'b1;
                            res.empty_frame   = 1'b1;
                        end
                        else
                        begin
                            phase_next = PH_PAYLOAD;
                        end
                    end
                end
                PH_PAYLOAD:
                begin
                    key_pos_next     = key_pos_reg + 2'd1;
                    remaining_next   = remaining_reg - LENGTH_WIDTH'(1);
                    res_valid        = 1'b1;
                    res.payload_byte = data ^ (mask_on_reg ? key_byte : 8'h00);
                    if (remaining_reg == LENGTH_WIDTH'(1))
                    begin
                        phase_next        = PH_FIRST;
                        res.last_of_frame = 1'b1;
                    end
                end
                default:
                begin
                    phase_next = PH_FIRST;
                end
            endcase
        end
    end

    // parser state
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            phase_reg     <= PH_FIRST;
            hdr_left_reg  <= '0;
            remaining_reg <= '0;
            key_reg       <= '0;
            mask_on_reg   <= 1'b0;
            key_pos_reg   <= '0;
            closed_reg    <= 1'b0;
        end
        else
        begin
            phase_reg     <= phase_next;
            hdr_left_reg  <= hdr_left_next;
            remaining_reg <= remaining_next;
            key_reg       <= key_next;
            mask_on_reg   <= mask_on_next;
            key_pos_reg   <= key_pos_next;
            closed_reg    <= closed_next;
        end
    end

    // a closed stream gives no more results
    a_closed_silent: assert property (@(posedge clk) disable iff (!rst_n)
        closed_reg |-> !res_valid)
        else $error("result after stream closed");

    // an error result closes the stream
    a_error_closes: assert property (@(posedge clk) disable iff (!rst_n)
        (res_valid && res.frame_error) |=> closed_reg)
        else $error("error did not close stream");

    // payload phase always has bytes still due
    a_payload_nonzero: assert property (@(posedge clk) disable iff (!rst_n)
        (phase_reg == PH_PAYLOAD) |-> (remaining_reg != '0))
        else $error("payload phase with no bytes due");

    // empty marker is a last marker and never an error
    a_empty_marks_last: assert property (@(posedge clk) disable iff (!rst_n)
        (res_valid && res.empty_frame) |-> (res.last_of_frame && !res.frame_error))
        else $error("bad empty-frame marker");

endmodule

`default_nettype wire

FILE: rtl/websocket_frame_deframer_unit.sv
// websocket deframer: one stream byte per item, at most one result per item
// the result is registered: an accepted item passes the input register, then the parser step, then the result register
// one item per cycle while the result register is not stalled, set by the single-pass parser step between the registers
// stalls propagate back from out_stall through the result register within the same cycle
// reset: rst_n async active low; parser expects a first header byte, stream open
`default_nettype none

module websocket_frame_deframer_unit (
    input  wire logic       clk,
    input  wire logic       rst_n,
    input  wire logic       in_valid,
    output logic            in_stall,
    input  wire logic [7:0] frame_byte,
    output logic            out_valid,
    input  wire logic       out_stall,
    output logic [7:0]      payload_byte,
    output logic            last_of_frame,
    output logic            empty_frame,
    output logic            frame_error
);
    import wsdf_pkg::*;

    logic         in_valid_reg;
    logic [7:0]   byte_reg;
    logic         out_valid_reg;
    wsdf_result_t out_reg;

    logic         advance;
    logic         res_valid;
    wsdf_result_t res;

    // item in the input register moves on when the result register is empty or not stalled
    assign advance  = in_valid_reg && (!out_valid_reg || !out_stall);
    assign in_stall = in_valid_reg && !advance;

    wsdf_parser u_parser (
        .clk       (clk),
        .rst_n     (rst_n),
        .step      (advance),
        .data      (byte_reg),
        .res_valid (res_valid),
        .res       (res)
    );

    // input register
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            in_valid_reg <= 1'b0;
        end
        else if (!in_stall)
        begin
            in_valid_reg <= in_valid;
        end
    end

    always_ff @(posedge clk)
    begin
        if (in_valid && !in_stall)
        begin
            byte_reg <= frame_byte;
        end
    end

    // result register
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
        end
        else if (advance)
        begin
            out_valid_reg <= res_valid;
        end
        else if (!out_stall)
        begin
            out_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (advance && res_valid)
        begin
            out_reg <= res;
        end
    end

    assign out_valid     = out_valid_reg;
    assign payload_byte  = out_reg.payload_byte;
    assign last_of_frame = out_reg.last_of_frame;
    assign empty_frame   = out_reg.empty_frame;
    assign frame_error   = out_reg.frame_error;

endmodule

`default_nettype wire
